### rtl/core/rwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared types and constants of the replay window check unit.
// ----------------------------------------------------------------------------
package rwc_pkg;

	localparam int unsigned WINDOW_BITS_DEF = 64;
	localparam int unsigned CTR_W           = 32;
	localparam int unsigned VERDICT_W       = 3;
	localparam int unsigned IN_DATA_W       = 64;
	localparam int unsigned OUT_DATA_W      = 8;

	typedef enum logic [VERDICT_W-1:0] {
		V_FIRST     = 3'd0,
		V_NEW       = 3'd1,
		V_REORDERED = 3'd2,
		V_OLD_BOOT  = 3'd3,
		V_STALE     = 3'd4,
		V_DUPLICATE = 3'd5
	} verdict_t;

	// window state apart from the bitmap, whose width follows the window size
	typedef struct packed {
		logic             seeded;
		logic [CTR_W-1:0] boot;
		logic [CTR_W-1:0] high;
	} rwc_ctr_t;

	// serial-number "newer": difference non-zero and below half the range
	function automatic logic is_newer(input logic [CTR_W-1:0] d);
		is_newer = (d != '0) && !d[CTR_W-1];
	endfunction

	function automatic logic is_accept(input verdict_t v);
		is_accept = (v == V_FIRST) || (v == V_NEW) || (v == V_REORDERED);
	endfunction

endpackage

### rtl/core/rwc_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_judge
// Verdict and next window state for one packet against the current window.
// ----------------------------------------------------------------------------
module rwc_judge #(
	parameter int unsigned WINDOW_BITS = rwc_pkg::WINDOW_BITS_DEF
) (
	input  logic [rwc_pkg::CTR_W-1:0] boot_count,
	input  logic [rwc_pkg::CTR_W-1:0] packet_count,
	input  rwc_pkg::rwc_ctr_t         cur,
	input  logic [WINDOW_BITS-1:0]    mask_cur,
	output rwc_pkg::rwc_ctr_t         nxt,
	output logic [WINDOW_BITS-1:0]    mask_nxt,
	output rwc_pkg::verdict_t         verdict
);

	localparam int unsigned IDX_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
	localparam logic [WINDOW_BITS-1:0] ONE = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
	localparam logic [rwc_pkg::CTR_W-1:0] WIN = rwc_pkg::CTR_W'(WINDOW_BITS);

	logic [rwc_pkg::CTR_W-1:0] boot_d;
	logic [rwc_pkg::CTR_W-1:0] fwd_d;
	logic [rwc_pkg::CTR_W-1:0] back_d;
	logic [WINDOW_BITS-1:0]    back_bit;

	assign boot_d   = boot_count - cur.boot;
	assign fwd_d    = packet_count - cur.high;
	assign back_d   = cur.high - packet_count;
	assign back_bit = ONE << back_d[IDX_W-1:0];

	always_comb begin
		nxt      = cur;
		mask_nxt = mask_cur;
		verdict  = rwc_pkg::V_FIRST;
		if (!cur.seeded) begin
			nxt.seeded = 1'b1;
			nxt.boot   = boot_count;
			nxt.high   = packet_count;
			mask_nxt   = ONE;
			verdict    = rwc_pkg::V_FIRST;
		end else if (boot_count != cur.boot) begin
			if (rwc_pkg::is_newer(boot_d)) begin
				nxt.boot = boot_count;
				nxt.high = packet_count;
				mask_nxt = ONE;
				verdict  = rwc_pkg::V_NEW;
			end else begin
				verdict = rwc_pkg::V_OLD_BOOT;
			end
		end else if (rwc_pkg::is_newer(fwd_d)) begin
			// slide; a jump past the window leaves only the new counter
			if (fwd_d >= WIN) begin
				mask_nxt = ONE;
			end else begin
				mask_nxt = (mask_cur << fwd_d[IDX_W-1:0]) | ONE;
			end
			nxt.high = packet_count;
			verdict  = rwc_pkg::V_NEW;
		end else if (back_d >= WIN) begin
			verdict = rwc_pkg::V_STALE;
		end else if ((mask_cur & back_bit) != '0) begin
			verdict = rwc_pkg::V_DUPLICATE;
		end else begin
			mask_nxt = mask_cur | back_bit;
			verdict  = rwc_pkg::V_REORDERED;
		end
	end

endmodule

### rtl/core/replay_window_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replay_window_check_unit
// Sliding-window anti-replay check on boot epoch and packet counter.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one request per packet, s_tdata = {packet_count,
//   boot_count}. Master stream m_*: one verdict per request, in order,
//   m_tdata = {4'b0, accepted, verdict}.
//   Verdicts: first, new, reordered (accepted); old boot, stale, duplicate
//   (rejected).
// Path: each request is judged on leaving the input register; its verdict is registered for m_*.
// Throughput: one request per cycle while m_tready stays high. The window state
//   is read and rewritten in the same cycle the request leaves the input
//   register, so the next request always sees the updated window.
// Reset: arst_n clears both stage valids and the window; the first request
//   after reset seeds the window and is reported as first.
// Stall: while m_tready is low with a verdict held, the input register keeps
//   one more request; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module replay_window_check_unit #(
	parameter int unsigned WINDOW_BITS = rwc_pkg::WINDOW_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rwc_pkg::IN_DATA_W-1:0]  s_tdata,  // boot_count[31:0], packet_count[63:32]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rwc_pkg::OUT_DATA_W-1:0] m_tdata   // verdict[2:0], accepted[3], zero[7:4]
);

	// input register
	logic                            valid_s1;
	logic [rwc_pkg::CTR_W-1:0]       boot_s1;
	logic [rwc_pkg::CTR_W-1:0]       pkt_s1;

	// result register
	logic                            valid_s2;
	rwc_pkg::verdict_t               verdict_s2;
	logic                            accepted_s2;

	// window state
	rwc_pkg::rwc_ctr_t               ctr_q;
	logic [WINDOW_BITS-1:0]          mask_q;

	rwc_pkg::rwc_ctr_t               ctr_nxt;
	logic [WINDOW_BITS-1:0]          mask_nxt;
	rwc_pkg::verdict_t               verdict;

	logic                            advance;
	logic                            take_in;

	// request moves from s1 into the result register when that is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			boot_s1 <= s_tdata[rwc_pkg::CTR_W-1:0];
			pkt_s1  <= s_tdata[2*rwc_pkg::CTR_W-1:rwc_pkg::CTR_W];
		end
	end

	rwc_judge #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_judge (
		.boot_count  (boot_s1),
		.packet_count(pkt_s1),
		.cur         (ctr_q),
		.mask_cur    (mask_q),
		.nxt         (ctr_nxt),
		.mask_nxt    (mask_nxt),
		.verdict     (verdict)
	);

	// window updates only as the request is judged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= '0;
			mask_q <= '0;
		end else if (advance) begin
			ctr_q  <= ctr_nxt;
			mask_q <= mask_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2  <= verdict;
			accepted_s2 <= rwc_pkg::is_accept(verdict);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, accepted_s2, verdict_s2};

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_accept_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (accepted_s2 == rwc_pkg::is_accept(verdict_s2)))
		else $error("accepted flag disagrees with verdict");

	a_seed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_q.seeded |=> ctr_q.seeded)
		else $error("window lost its seed");

	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !ctr_q.seeded) |=> (verdict_s2 == rwc_pkg::V_FIRST))
		else $error("unseeded request not reported as first");

	a_head_bit: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_q.seeded |-> mask_q[0])
		else $error("newest counter missing from bitmap");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |=> valid_s2)
		else $error("held verdict dropped");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the replay window check unit. A directed table
// covers the epoch and window corner cases, then random packet traffic mostly
// clusters around the current window edge. Every request is scored against a
// local model of the window or a typed table verdict. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned WIN           = rwc_pkg::WINDOW_BITS_DEF;
	localparam int unsigned RANDOM_ITEMS  = 600;
	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned DIRECTED_ROWS = 24;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [rwc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;  // boot_count[31:0], packet_count[63:32]
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [rwc_pkg::OUT_DATA_W-1:0] m_tdata;        // verdict[2:0], accepted[3], zero[7:4]

	typedef struct {
		rwc_pkg::verdict_t verdict;
		logic              accepted;
	} verdict_rec_t;

	typedef struct packed {
		logic [rwc_pkg::CTR_W-1:0] boot;
		logic [rwc_pkg::CTR_W-1:0] pkt;
		logic                      typed;   // verdict column below holds the answer
		rwc_pkg::verdict_t         verdict;
	} stim_row_t;

	verdict_rec_t verdicts_due[$];
	stim_row_t    directed_rows [DIRECTED_ROWS];

	// window model
	logic                      win_seeded = 1'b0;
	logic [rwc_pkg::CTR_W-1:0] win_boot   = '0;
	logic [rwc_pkg::CTR_W-1:0] win_high   = '0;
	logic [63:0]               win_seen   = '0;

	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;
	bit          tx_calm     = 1'b0;
	bit          rx_calm     = 1'b0;

	replay_window_check_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic ctr_ahead(input logic [rwc_pkg::CTR_W-1:0] a,
			input logic [rwc_pkg::CTR_W-1:0] b);
		logic [rwc_pkg::CTR_W-1:0] d;
		d = a - b;
		return (d != '0) && (d[rwc_pkg::CTR_W-1] == 1'b0);
	endfunction

	// updates the window model and returns the verdict for one packet
	function automatic rwc_pkg::verdict_t judge_packet(input logic [rwc_pkg::CTR_W-1:0] boot,
			input logic [rwc_pkg::CTR_W-1:0] pkt);
		logic [rwc_pkg::CTR_W-1:0] span;
		logic [63:0]               keep;
		keep = {64{1'b1}} >> (64 - WIN);
		if (!win_seeded) begin
			win_seeded = 1'b1;
			win_boot   = boot;
			win_high   = pkt;
			win_seen   = 64'd1;
			return rwc_pkg::V_FIRST;
		end
		if (boot != win_boot) begin
			if (!ctr_ahead(boot, win_boot))
				return rwc_pkg::V_OLD_BOOT;
			win_boot = boot;
			win_high = pkt;
			win_seen = 64'd1;
			return rwc_pkg::V_NEW;
		end
		if (ctr_ahead(pkt, win_high)) begin
			span = pkt - win_high;
			if (span >= WIN)
				win_seen = 64'd1;
			else
				win_seen = ((win_seen << span) | 64'd1) & keep;
			win_high = pkt;
			return rwc_pkg::V_NEW;
		end
		span = win_high - pkt;
		if (span >= WIN)
			return rwc_pkg::V_STALE;
		if (win_seen[span[5:0]])
			return rwc_pkg::V_DUPLICATE;
		win_seen[span[5:0]] = 1'b1;
		return rwc_pkg::V_REORDERED;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one request, returns at the edge where it is taken
	task automatic send_request(input logic [rwc_pkg::CTR_W-1:0] boot,
			input logic [rwc_pkg::CTR_W-1:0] pkt,
			input logic typed, input rwc_pkg::verdict_t typed_verdict);
		int unsigned       gap;
		verdict_rec_t      rec;
		rwc_pkg::verdict_t v;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pkt, boot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		v = judge_packet(boot, pkt);
		rec.verdict  = typed ? typed_verdict : v;
		rec.accepted = (rec.verdict == rwc_pkg::V_FIRST) || (rec.verdict == rwc_pkg::V_NEW) ||
			(rec.verdict == rwc_pkg::V_REORDERED);
		verdicts_due.push_back(rec);
	endtask

	// receiver: random bursts of ready with gaps between
	initial begin
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (!rx_calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap(1'b0) + 1) @(posedge clk);
			end
		end
	end

	// scoreboard
	always @(posedge clk) begin
		verdict_rec_t rec;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: verdict %0d with no request pending", $time, m_tdata[2:0]);
				err_count++;
			end else begin
				rec = verdicts_due.pop_front();
				if (m_tdata[2:0] != rec.verdict) begin
					$display("%0t: verdict expected %0d got %0d", $time, rec.verdict,
						m_tdata[2:0]);
					err_count++;
				end
				if (m_tdata[3] != rec.accepted) begin
					$display("%0t: accepted expected %0d got %0d", $time, rec.accepted,
						m_tdata[3]);
					err_count++;
				end
				if (m_tdata[7:4] != 4'd0) begin
					$display("%0t: pad bits expected 0 got %0h", $time, m_tdata[7:4]);
					err_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [rwc_pkg::CTR_W-1:0] boot;
		logic [rwc_pkg::CTR_W-1:0] pkt;
		int unsigned               r;

		directed_rows = '{
			'{32'd5,          32'd100,        1'b1, rwc_pkg::V_FIRST},
			'{32'd5,          32'd100,        1'b1, rwc_pkg::V_DUPLICATE},  // same as newest
			'{32'd5,          32'd101,        1'b1, rwc_pkg::V_NEW},
			'{32'd5,          32'd99,         1'b0, rwc_pkg::V_FIRST},
			'{32'd5,          32'd99,         1'b0, rwc_pkg::V_FIRST},
			'{32'd5,          32'd38,         1'b0, rwc_pkg::V_FIRST},      // oldest slot
			'{32'd5,          32'd37,         1'b1, rwc_pkg::V_STALE},      // one past window
			'{32'd5,          32'h8000_0065,  1'b1, rwc_pkg::V_STALE},      // half range away
			'{32'd4,          32'd0,          1'b1, rwc_pkg::V_OLD_BOOT},
			'{32'h8000_0005,  32'd0,          1'b1, rwc_pkg::V_OLD_BOOT},   // epoch half range
			'{32'd5,          32'd164,        1'b0, rwc_pkg::V_FIRST},      // slide by 63
			'{32'd5,          32'd101,        1'b0, rwc_pkg::V_FIRST},
			'{32'd5,          32'd228,        1'b0, rwc_pkg::V_FIRST},      // full window jump
			'{32'd5,          32'd164,        1'b0, rwc_pkg::V_FIRST},
			'{32'd5,          32'd227,        1'b0, rwc_pkg::V_FIRST},
			'{32'd5,          32'h8000_00E3,  1'b0, rwc_pkg::V_FIRST},      // largest forward step
			'{32'hFFFF_FFFF,  32'd0,          1'b1, rwc_pkg::V_OLD_BOOT},
			'{32'h8000_0004,  32'hFFFF_FFFF,  1'b0, rwc_pkg::V_FIRST},      // newer epoch restarts
			'{32'h8000_0004,  32'd0,          1'b0, rwc_pkg::V_FIRST},      // counter wraps
			'{32'h8000_0004,  32'hFFFF_FFFE,  1'b0, rwc_pkg::V_FIRST},
			'{32'h8000_0004,  32'hFFFF_FFFF,  1'b0, rwc_pkg::V_FIRST},
			'{32'hFFFF_FFFF,  32'd0,          1'b0, rwc_pkg::V_FIRST},
			'{32'd0,          32'hFFFF_FFFF,  1'b0, rwc_pkg::V_FIRST},      // epoch wraps
			'{32'd0,          32'hFFFF_FFC0,  1'b0, rwc_pkg::V_FIRST}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].boot, directed_rows[i].pkt,
				directed_rows[i].typed, directed_rows[i].verdict);

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			// let the pipe drain completely once mid-run
			if (n == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				while (verdicts_due.size() != 0) @(posedge clk);
			end
			r    = $urandom_range(0, 99);
			boot = win_boot;
			if (r < 55) begin
				pkt = win_high + $urandom_range(0, 78) - 70;
			end else if (r < 70) begin
				pkt = win_high + $urandom_range(1, 200);
			end else if (r < 78) begin
				boot = win_boot + $urandom_range(1, 3);
				pkt  = $urandom();
			end else if (r < 84) begin
				boot = win_boot - $urandom_range(1, 1000);
				pkt  = win_high + $urandom_range(0, 4);
			end else if (r < 90) begin
				pkt = win_high + 32'h8000_0000 + $urandom_range(0, 4) - 2;
			end else begin
				boot = $urandom();
				pkt  = $urandom();
			end
			send_request(boot, pkt, 1'b0, rwc_pkg::V_FIRST);
		end
		s_tvalid <= 1'b0;

		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
